// ----- hdl/rse_pkg.sv -----
// ----------------------------------------------------------------------------
// rse_pkg: shared types, constants and exponent tables
// Fixed-point widths and the three Q1.16 exponent tables used by the
// row softmax engine.
// ----------------------------------------------------------------------------
package rse_pkg;

    // defaults for the top level parameters
    localparam int ROW_MAX_DEF     = 64;
    localparam int SCORE_WIDTH_DEF = 16;
    localparam int PROB_WIDTH_DEF  = 16;

    // row length register
    localparam int             LEN_W     = 7;
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

    // exponent datapath, Q1.16 where 65536 is 1.0
    localparam int EXP_W      = 17;
    localparam int PROD_W     = 2 * EXP_W;
    localparam int SUM_W      = 23;
    localparam int EXP_CUTOFF = 4096;
    localparam logic [PROD_W-1:0] ROUND_Q16 = 34'd32768;
    localparam logic [SUM_W-1:0]  EXP_ONE   = 23'd65536;

    // reciprocal 2^40 / sum, one quotient bit per step
    localparam int             DIV_W    = 6;
    localparam logic [DIV_W-1:0] DIV_LAST = 6'd40;
    localparam int             RECIP_W  = 25;
    localparam int             NORM_W   = EXP_W + RECIP_W;
    localparam int             NORM_SHIFT = 40;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_EXP,
        ST_DIV,
        ST_EMIT
    } t_state;

    // round(65536 * exp(-k))
    function automatic logic [EXP_W-1:0] exp_int(input logic [3:0] k);
        logic [EXP_W-1:0] v;
        case (k)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // round(65536 * exp(-i/16))
    function automatic logic [EXP_W-1:0] exp_mid(input logic [3:0] i);
        logic [EXP_W-1:0] v;
        case (i)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd61565;
            4'd2:    v = 17'd57835;
            4'd3:    v = 17'd54331;
            4'd4:    v = 17'd51039;
            4'd5:    v = 17'd47947;
            4'd6:    v = 17'd45042;
            4'd7:    v = 17'd42313;
            4'd8:    v = 17'd39750;
            4'd9:    v = 17'd37341;
            4'd10:   v = 17'd35079;
            4'd11:   v = 17'd32954;
            4'd12:   v = 17'd30957;
            4'd13:   v = 17'd29081;
            4'd14:   v = 17'd27319;
            default: v = 17'd25664;
        endcase
        return v;
    endfunction

    // round(65536 * exp(-j/256))
    function automatic logic [EXP_W-1:0] exp_low(input logic [3:0] j);
        logic [EXP_W-1:0] v;
        case (j)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd65280;
            4'd2:    v = 17'd65026;
            4'd3:    v = 17'd64772;
            4'd4:    v = 17'd64520;
            4'd5:    v = 17'd64268;
            4'd6:    v = 17'd64018;
            4'd7:    v = 17'd63768;
            4'd8:    v = 17'd63520;
            4'd9:    v = 17'd63272;
            4'd10:   v = 17'd63025;
            4'd11:   v = 17'd62780;
            4'd12:   v = 17'd62535;
            4'd13:   v = 17'd62291;
            4'd14:   v = 17'd62048;
            default: v = 17'd61806;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/row_softmax_engine.sv -----
// ----------------------------------------------------------------------------
// row_softmax_engine: max-subtracted softmax over rows of Q8.8 scores
// Stores a row, forms exp(score - max) per element, sums them and emits
// each element scaled by the reciprocal of the sum as unsigned Q0.PROB_WIDTH.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_valid / o_stall) carries one signed Q8.8 score per
//   transfer. After row_length scores (register written by i_cfg_wr_en,
//   0 acts as 1, values above ROW_MAX act as ROW_MAX) the row is closed.
//   Output channel (o_valid / i_stall) then delivers one probability per
//   element in arrival order, o_row_end set on the last one.
//   A row of n scores runs in three passes over the row memories: the
//   load pass, the exponent pass and the emit pass, with a bit-serial
//   reciprocal divider between the last two. o_stall is high from the
//   last score of a row until the emit pass has drained into the output
//   register; the next row loads while that last result still waits.
//   A stall on the output freezes the emit pipeline in place.
//   Reset (synchronous, active low) empties the row, clears the running
//   maximum and sum, drops o_valid and sets row_length to 64.
// ----------------------------------------------------------------------------
module row_softmax_engine #(
    parameter int ROW_MAX     = rse_pkg::ROW_MAX_DEF,
    parameter int SCORE_WIDTH = rse_pkg::SCORE_WIDTH_DEF,
    parameter int PROB_WIDTH  = rse_pkg::PROB_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [rse_pkg::LEN_W-1:0]     i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SCORE_WIDTH-1:0] i_score,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [PROB_WIDTH-1:0]         o_prob,
    output logic                          o_row_end
);

    localparam int AW = $clog2(ROW_MAX);
    localparam int CW = $clog2(ROW_MAX + 1);
    localparam int DW = SCORE_WIDTH + 1;
    localparam int EW = rse_pkg::EXP_W;
    localparam int NW = rse_pkg::NORM_W;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    rse_pkg::t_state r_state, n_state;

    logic [rse_pkg::LEN_W-1:0]       r_len;
    logic [CW-1:0]                   r_fill;
    logic [CW-1:0]                   r_idx;
    logic signed [SCORE_WIDTH-1:0]   r_max;
    logic [rse_pkg::SUM_W-1:0]       r_sum;

    logic [SCORE_WIDTH-1:0]          row_mem [ROW_MAX];
    logic [EW-1:0]                   exp_mem [ROW_MAX];

    // exponent pass pipeline
    logic                            r_v0, r_v1, r_v2;
    logic [AW-1:0]                   r_a0, r_a1, r_a2;
    logic signed [SCORE_WIDTH-1:0]   r_rd_score;
    logic [rse_pkg::PROD_W-1:0]      r_fprod, r_eprod;
    logic [3:0]                      r_k1;
    logic                            r_cut1, r_cut2;

    // divider
    logic [rse_pkg::DIV_W-1:0]       r_div_cnt;
    logic [rse_pkg::SUM_W-1:0]       r_rem;
    logic [rse_pkg::RECIP_W-1:0]     r_recip;

    // emit pipeline
    logic                            r_ev0, r_ev1;
    logic                            r_last0, r_last1;
    logic [EW-1:0]                   r_rd_exp;
    logic [NW-1:0]                   r_nprod;
    logic                            r_out_valid;
    logic [PROB_WIDTH-1:0]           r_prob;
    logic                            r_row_end;

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    logic [CW-1:0] len_eff;
    logic          in_accept, row_done;
    logic          exp_issue, exp_done, div_done;
    logic          pipe_en, emit_issue, emit_done;

    always_comb begin
        if (r_len == '0) begin
            len_eff = CW'(1);
        end else if (r_len > rse_pkg::LEN_W'(ROW_MAX)) begin
            len_eff = CW'(ROW_MAX);
        end else begin
            len_eff = CW'(r_len);
        end
    end

    // output block of the sequencer
    always_comb begin
        o_stall    = (r_state != rse_pkg::ST_LOAD);
        in_accept  = i_valid && (r_state == rse_pkg::ST_LOAD);
        row_done   = in_accept && ((r_fill + CW'(1)) >= len_eff);
        exp_issue  = (r_state == rse_pkg::ST_EXP) && (r_idx < r_fill);
        exp_done   = (r_state == rse_pkg::ST_EXP) && (r_idx == r_fill)
                     && !r_v0 && !r_v1 && !r_v2;
        div_done   = (r_state == rse_pkg::ST_DIV) && (r_div_cnt == '0);
        pipe_en    = !(r_out_valid && i_stall);
        emit_issue = (r_state == rse_pkg::ST_EMIT) && (r_idx < r_fill) && pipe_en;
        emit_done  = (r_state == rse_pkg::ST_EMIT) && (r_idx == r_fill)
                     && !r_ev0 && !r_ev1;
    end

    // next state block of the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            rse_pkg::ST_LOAD: begin
                if (row_done) n_state = rse_pkg::ST_EXP;
            end
            rse_pkg::ST_EXP: begin
                if (exp_done) n_state = rse_pkg::ST_DIV;
            end
            rse_pkg::ST_DIV: begin
                if (div_done) n_state = rse_pkg::ST_EMIT;
            end
            rse_pkg::ST_EMIT: begin
                if (emit_done) n_state = rse_pkg::ST_LOAD;
            end
            default: n_state = rse_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rse_pkg::ST_LOAD;
            r_len   <= rse_pkg::LEN_RESET;
            r_fill  <= '0;
            r_idx   <= '0;
            r_max   <= {1'b1, {(SCORE_WIDTH-1){1'b0}}};
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_len <= i_cfg_wr_data;
            end
            if (in_accept) begin
                r_fill <= r_fill + CW'(1);
                if (i_score > r_max) r_max <= i_score;
            end
            if (row_done || div_done) begin
                r_idx <= '0;
            end else if (exp_issue || emit_issue) begin
                r_idx <= r_idx + CW'(1);
            end
            if (emit_done) begin
                r_fill <= '0;
                r_max  <= {1'b1, {(SCORE_WIDTH-1){1'b0}}};
            end
        end
    end

    // ------------------------------------------------------------------
    // row memory: written while loading, read in the exponent pass
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_accept) row_mem[r_fill[AW-1:0]] <= i_score;
        if (exp_issue) r_rd_score <= row_mem[r_idx[AW-1:0]];
    end

    // ------------------------------------------------------------------
    // exponent pass: read, mid*low, int*f, write back and accumulate
    // ------------------------------------------------------------------
    logic [DW-1:0]           diff;
    logic [63:0]             diff_x;
    logic                    cut0;
    logic [EW-1:0]           f_val;
    logic [EW-1:0]           e_val;

    always_comb begin
        // max minus score never goes negative
        diff   = {r_max[SCORE_WIDTH-1], r_max} - {r_rd_score[SCORE_WIDTH-1], r_rd_score};
        diff_x = 64'(diff);
        cut0   = diff_x >= 64'(rse_pkg::EXP_CUTOFF);
        f_val  = EW'((r_fprod + rse_pkg::ROUND_Q16) >> 16);
        e_val  = r_cut2 ? '0 : EW'((r_eprod + rse_pkg::ROUND_Q16) >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= exp_issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a0    <= r_idx[AW-1:0];
        r_a1    <= r_a0;
        r_a2    <= r_a1;
        r_k1    <= diff_x[11:8];
        r_cut1  <= cut0;
        r_cut2  <= r_cut1;
        r_fprod <= rse_pkg::PROD_W'(rse_pkg::exp_mid(diff_x[7:4]))
                   * rse_pkg::PROD_W'(rse_pkg::exp_low(diff_x[3:0]));
        r_eprod <= rse_pkg::PROD_W'(rse_pkg::exp_int(r_k1)) * rse_pkg::PROD_W'(f_val);
    end

    // exponent memory: written in the exponent pass, read while emitting
    always_ff @(posedge i_clk) begin
        if (r_v2) exp_mem[r_a2] <= e_val;
        if (emit_issue) r_rd_exp <= exp_mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (emit_done) begin
            r_sum <= '0;
        end else if (r_v2) begin
            r_sum <= r_sum + rse_pkg::SUM_W'(e_val);
        end
    end

    // ------------------------------------------------------------------
    // reciprocal: restoring division of 2^40 by the sum, msb first
    // ------------------------------------------------------------------
    logic [rse_pkg::SUM_W-1:0] divisor;
    logic [rse_pkg::SUM_W:0]   rem_shift;
    logic                      q_bit;

    always_comb begin
        divisor   = (r_sum == '0) ? rse_pkg::SUM_W'(1) : r_sum;
        rem_shift = {r_rem, (r_div_cnt == rse_pkg::DIV_LAST)};
        q_bit     = rem_shift >= {1'b0, divisor};
    end

    always_ff @(posedge i_clk) begin
        if (exp_done) begin
            r_div_cnt <= rse_pkg::DIV_LAST;
            r_rem     <= '0;
            r_recip   <= '0;
        end else if (r_state == rse_pkg::ST_DIV) begin
            r_div_cnt <= r_div_cnt - rse_pkg::DIV_W'(1);
            r_rem     <= q_bit ? rse_pkg::SUM_W'(rem_shift - {1'b0, divisor})
                               : rse_pkg::SUM_W'(rem_shift);
            r_recip   <= {r_recip[rse_pkg::RECIP_W-2:0], q_bit};
        end
    end

    // ------------------------------------------------------------------
    // emit pass: read, scale by reciprocal, round, saturate
    // ------------------------------------------------------------------
    logic [NW:0] norm_rnd;
    logic [NW:0] norm_sh;
    logic [PROB_WIDTH-1:0] prob_sat;

    always_comb begin
        norm_rnd = {1'b0, r_nprod}
                   + ((NW + 1)'(1) << (rse_pkg::NORM_SHIFT - 1 - PROB_WIDTH));
        norm_sh  = norm_rnd >> (rse_pkg::NORM_SHIFT - PROB_WIDTH);
        prob_sat = (|norm_sh[NW:PROB_WIDTH]) ? '1 : norm_sh[PROB_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev0       <= 1'b0;
            r_ev1       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_ev0       <= emit_issue;
            r_ev1       <= r_ev0;
            r_out_valid <= r_ev1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_last0   <= (r_idx + CW'(1)) == r_fill;
            r_last1   <= r_last0;
            r_nprod   <= NW'(r_rd_exp) * NW'(r_recip);
            r_prob    <= prob_sat;
            r_row_end <= r_last1;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_prob    = r_prob;
    assign o_row_end = r_row_end;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_row_close_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        row_done |=> o_stall)
        else $error("input not stalled after the last score of a row");

    a_sum_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rse_pkg::ST_DIV) |-> (r_sum >= rse_pkg::EXP_ONE))
        else $error("exponent sum below one at the divider");

    a_row_end_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_row_end) |=> !o_valid)
        else $error("result follows the last result of a row too early");

    a_emit_holds_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rse_pkg::ST_EMIT) |-> (r_fill != '0))
        else $error("emit pass with an empty row");

endmodule

// ----- tb/tb_row_softmax_engine.sv -----
// ----------------------------------------------------------------------------
// tb_row_softmax_engine: self-checking bench for the row softmax engine
// Streams rows of Q8.8 scores under several row lengths, predicts every
// normalized probability in fixed point and compares each output transfer
// against the oldest prediction, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_row_softmax_engine;

    localparam int SW       = rse_pkg::SCORE_WIDTH_DEF;
    localparam int PW       = rse_pkg::PROB_WIDTH_DEF;
    localparam int LW       = rse_pkg::LEN_W;
    localparam int ROWS_MAX = rse_pkg::ROW_MAX_DEF;
    localparam int SETTLE   = 200;
    localparam int PHASES   = 12;

    // round(65536 * exp(-k)), exp(-i/16), exp(-j/256)
    localparam logic [16:0] EXP_INT_LUT [16] = '{
        65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1, 0, 0, 0, 0};
    localparam logic [16:0] EXP_MID_LUT [16] = '{
        65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
        39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
    localparam logic [16:0] EXP_LOW_LUT [16] = '{
        65536, 65280, 65026, 64772, 64520, 64268, 64018, 63768,
        63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};

    typedef struct packed {
        logic [PW-1:0] prob;
        logic          row_end;
    } t_prob_item;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [LW-1:0]        cfg_wr_data = '0;
    logic                 score_valid = 1'b0;
    logic                 score_stall;
    logic signed [SW-1:0] score = '0;
    logic                 prob_valid;
    logic                 prob_stall = 1'b0;
    logic [PW-1:0]        prob;
    logic                 row_end;

    // stimulus side
    logic [SW-1:0] score_q [$];
    int            scores_sent = 0;
    int            src_idle_pct = 0;
    int            sink_stall_pct = 0;
    int            gap_left = 0;
    int            stall_left = 0;

    // predictor side
    t_prob_item           prob_expect_q [$];
    logic [LW-1:0]        row_len_reg;
    logic signed [SW-1:0] row_buf [ROWS_MAX];
    int unsigned          row_fill;
    logic signed [SW-1:0] row_peak;
    int                   scores_taken = 0;
    logic                 score_taken = 1'b0;
    int                   err_count = 0;

    row_softmax_engine uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_valid       (score_valid),
        .o_stall       (score_stall),
        .i_score       (score),
        .o_valid       (prob_valid),
        .i_stall       (prob_stall),
        .o_prob        (prob),
        .o_row_end     (row_end)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int pick_idle(input int pct);
        if (int'($urandom_range(99)) >= pct) return 0;
        if ($urandom_range(9) == 0) return int'($urandom_range(40, 10));
        return int'($urandom_range(3, 1));
    endfunction

    // exp(-d/256) in Q1.16, zero at a difference of 16 or more
    function automatic logic [16:0] exp_neg_q16(input int unsigned d);
        logic [63:0] frac;
        logic [63:0] e;
        if (d >= rse_pkg::EXP_CUTOFF) return '0;
        frac = (64'(EXP_MID_LUT[d[7:4]]) * 64'(EXP_LOW_LUT[d[3:0]]) + 64'd32768) >> 16;
        e    = (64'(EXP_INT_LUT[d[11:8]]) * frac + 64'd32768) >> 16;
        return e[16:0];
    endfunction

    function automatic void clear_row();
        row_fill = 0;
        row_peak = {1'b1, {(SW-1){1'b0}}};
    endfunction

    // add one score to the row; on the closing score queue every probability
    function automatic void take_score(input logic signed [SW-1:0] s);
        int unsigned len;
        logic [16:0] exps [ROWS_MAX];
        logic [22:0] sum;
        logic [63:0] recip;
        logic [63:0] p;
        t_prob_item  item;
        len = row_len_reg;
        if (len < 1) len = 1;
        if (len > ROWS_MAX) len = ROWS_MAX;
        if (row_fill >= ROWS_MAX) row_fill = ROWS_MAX - 1;
        row_buf[row_fill] = s;
        if (s > row_peak) row_peak = s;
        row_fill++;
        if (row_fill < len) return;
        sum = '0;
        for (int k = 0; k < row_fill; k++) begin
            exps[k] = exp_neg_q16(int'(row_peak) - int'(row_buf[k]));
            sum     = sum + 23'(exps[k]);
        end
        recip = (64'd1 << 40) / ((sum != 0) ? 64'(sum) : 64'd1);
        for (int k = 0; k < row_fill; k++) begin
            p = (64'(exps[k]) * recip + (64'd1 << (39 - PW))) >> (40 - PW);
            if (p > {PW{1'b1}}) p = {PW{1'b1}};
            item.prob    = p[PW-1:0];
            item.row_end = (k + 1 == row_fill);
            prob_expect_q.push_back(item);
        end
        clear_row();
    endfunction

    // monitor: check output transfers, then track config and input transfers
    always @(posedge clk) begin
        t_prob_item want;
        if (!rst_n) begin
            row_len_reg = rse_pkg::LEN_RESET;
            clear_row();
            score_taken = 1'b0;
        end else begin
            if (prob_valid && !prob_stall) begin
                if (prob_expect_q.size() == 0) begin
                    $display("%0t: result with none expected, prob %0d row_end %0b",
                             $time, prob, row_end);
                    err_count++;
                end else begin
                    want = prob_expect_q.pop_front();
                    if (prob !== want.prob) begin
                        $display("%0t: prob mismatch, expected %0d actual %0d",
                                 $time, want.prob, prob);
                        err_count++;
                    end
                    if (row_end !== want.row_end) begin
                        $display("%0t: row_end mismatch, expected %0b actual %0b",
                                 $time, want.row_end, row_end);
                        err_count++;
                    end
                end
            end
            if (cfg_wr_en) row_len_reg = cfg_wr_data;
            score_taken = score_valid && !score_stall;
            if (score_taken) begin
                take_score(score);
                scores_taken++;
            end
        end
    end

    // input driver
    always @(negedge clk) begin
        logic          nxt_valid;
        logic [SW-1:0] nxt_score;
        nxt_valid = score_valid;
        nxt_score = score;
        if (!rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (score_valid && score_taken) nxt_valid = 1'b0;
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (score_q.size() > 0) begin
                    nxt_valid = 1'b1;
                    nxt_score = score_q.pop_front();
                    gap_left  = pick_idle(src_idle_pct);
                end
            end
        end
        score_valid <= nxt_valid;
        score       <= nxt_score;
    end

    // output back-pressure
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            prob_stall <= 1'b1;
        end else begin
            stall_left = pick_idle(sink_stall_pct);
            prob_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    task automatic push_score(input int v);
        score_q.push_back(v[SW-1:0]);
        scores_sent++;
    endtask

    task automatic wait_drained();
        while (scores_taken != scores_sent || prob_expect_q.size() != 0)
            @(negedge clk);
    endtask

    // only written once the engine has gone quiet
    task automatic write_row_length(input int v);
        wait_drained();
        repeat (SETTLE) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v[LW-1:0];
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic int pick_score(input int center);
        int v;
        int r;
        r = int'($urandom_range(99));
        if (r < 25)      v = int'($urandom_range(65535)) - 32768;
        else if (r < 75) v = center + int'($urandom_range(4096)) - 2048;
        else             v = center + int'($urandom_range(16384)) - 8192;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    initial begin
        int phase_len [PHASES];
        int center;
        int n;
        phase_len = '{64, 127, 1, 2, 100, 7, 16, 33, 3, 0, 0, 0};
        phase_len[10] = int'($urandom_range(127));
        phase_len[11] = int'($urandom_range(127));
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero length acts as one: single-element rows saturate
        write_row_length(0);
        push_score(32767);
        push_score(-32768);
        push_score(0);

        // pairs at both ends of the exponent range
        write_row_length(2);
        push_score(-32768);
        push_score(32767);
        push_score(100);
        push_score(100);
        push_score(0);
        push_score(-4096);
        push_score(0);
        push_score(-4095);

        // length lowered below the scores already held
        write_row_length(5);
        push_score(1000);
        push_score(-200);
        push_score(500);
        write_row_length(2);
        push_score(300);

        // length raised mid-row
        write_row_length(3);
        push_score(-1234);
        push_score(-1300);
        write_row_length(6);
        push_score(-1100);
        push_score(-2000);
        push_score(-1234);
        push_score(-900);

        center = 0;
        for (int ph = 0; ph < PHASES; ph++) begin
            write_row_length(phase_len[ph]);
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 20; sink_stall_pct = 20; end
                2: begin src_idle_pct = 50; sink_stall_pct = 50; end
                default: begin src_idle_pct = 10; sink_stall_pct = 60; end
            endcase
            n = int'($urandom_range(50, 25));
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(7) == 0) center = int'($urandom_range(65535)) - 32768;
                push_score(pick_score(center));
            end
        end

        wait_drained();
        repeat (SETTLE) @(negedge clk);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
